// ===== hw/rtl/pcted_pkg.sv =====
// Package with the shared types, character constants and helper functions of the percent codec.
`timescale 1ns / 1ps

package pcted_pkg;

    // Character codes: the percent sign, used by both directions, and the unreserved marks.
    localparam logic [7:0] PCT_CHAR    = 8'h25;
    localparam logic [7:0] DASH_CHAR   = 8'h2D;
    localparam logic [7:0] UNDER_CHAR  = 8'h5F;
    localparam logic [7:0] DOT_CHAR    = 8'h2E;
    localparam logic [7:0] TILDE_CHAR  = 8'h7E;

    // Number of result bytes one item can produce, and the queue depth.
    localparam int CMD_BYTES  = 3;
    localparam int CNT_W      = $clog2(CMD_BYTES + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Decode escape phase.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // One item's worth of result bytes, handed from front to back.
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] data;
        logic [CNT_W-1:0]          count;
        logic                      last;
    } cmd_t;

    // True for ASCII letters, digits and - _ . ~
    function automatic logic is_unreserved(input logic [7:0] b);
        logic r;
        r = ((b >= 8'h30) && (b <= 8'h39)) ||
            ((b >= 8'h41) && (b <= 8'h5A)) ||
            ((b >= 8'h61) && (b <= 8'h7A)) ||
            (b == DASH_CHAR) || (b == UNDER_CHAR) ||
            (b == DOT_CHAR) || (b == TILDE_CHAR);
        return r;
    endfunction

    // Value of a hex digit in the low four bits; bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            r = {1'b0, b[3:0]};
        end else if (((b >= 8'h41) && (b <= 8'h46)) || ((b >= 8'h61) && (b <= 8'h66))) begin
            r = {1'b0, b[3:0] + 4'd9};
        end else begin
            r = 5'h10;
        end
        return r;
    endfunction

    // Uppercase hex character for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h37 + {4'd0, v};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pcted_front.sv =====
// Front end: takes input items, tracks the escape state and builds the result bytes of each item.
`timescale 1ns / 1ps

module pcted_front
    import pcted_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr,
    input  logic       cfg_dir,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output cmd_t       push_cmd
);

    logic       direction_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    cmd_t       cmd;

    // Direction and escape state; a direction write drops any pending escape.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            held_reg      <= 8'd0;
        end
        else if (cfg_wr)
        begin
            direction_reg <= cfg_dir;
            phase_reg     <= PH_IDLE;
            held_reg      <= 8'd0;
        end
        else if (in_accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // Classify the byte and work out the bytes it yields.
    always_comb
    begin
        logic [4:0] hv_in;
        logic [4:0] hv_held;
        logic       opens;
        hv_in      = hex_value(in_byte);
        hv_held    = hex_value(held_reg);
        opens      = (in_byte == PCT_CHAR) && !in_last;
        phase_next = phase_reg;
        held_next  = held_reg;
        cmd.data   = '0;
        cmd.count  = '0;
        cmd.last   = in_last;
        if (!direction_reg)
        begin
            // Encode: pass unreserved bytes, escape all others.
            if (is_unreserved(in_byte))
            begin
                cmd.data[0] = in_byte;
                cmd.count   = CNT_W'(1);
            end
            else
            begin
                cmd.data[0] = PCT_CHAR;
                cmd.data[1] = hex_char(in_byte[7:4]);
                cmd.data[2] = hex_char(in_byte[3:0]);
                cmd.count   = CNT_W'(3);
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_PCT:
                begin
                    if (!hv_in[4] && !in_last)
                    begin
                        held_next  = in_byte;
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        // Bad escape: the percent goes out literally.
                        cmd.data[0] = PCT_CHAR;
                        if (opens)
                        begin
                            phase_next = PH_PCT;
                            cmd.count  = CNT_W'(1);
                        end
                        else
                        begin
                            cmd.data[1] = in_byte;
                            cmd.count   = CNT_W'(2);
                            phase_next  = PH_IDLE;
                        end
                    end
                end
                PH_DIGIT:
                begin
                    held_next = 8'd0;
                    if (!hv_held[4] && !hv_in[4])
                    begin
                        cmd.data[0] = {hv_held[3:0], hv_in[3:0]};
                        cmd.count   = CNT_W'(1);
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        cmd.data[0] = PCT_CHAR;
                        cmd.data[1] = held_reg;
                        if (opens)
                        begin
                            phase_next = PH_PCT;
                            cmd.count  = CNT_W'(2);
                        end
                        else
                        begin
                            cmd.data[2] = in_byte;
                            cmd.count   = CNT_W'(3);
                            phase_next  = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    // No escape pending.
                    if (opens)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        cmd.data[0] = in_byte;
                        cmd.count   = CNT_W'(1);
                        phase_next  = PH_IDLE;
                    end
                end
            endcase
        end
    end

    // Items that produce no bytes stay out of the queue.
    assign push     = in_accept && (cmd.count != '0);
    assign push_cmd = cmd;

endmodule

// ===== hw/rtl/pcted_queue.sv =====
// Short queue of per-item result groups between the front and back ends.
`timescale 1ns / 1ps

module pcted_queue
    import pcted_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/pcted_back.sv =====
// Back end: sends the bytes of each queued group one per cycle while out_stall is low, through an output register.
`timescale 1ns / 1ps

module pcted_back
    import pcted_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             load;
    logic             at_end;

    // Output register is free when empty or being taken this cycle.
    assign load   = head_valid && (!out_valid_reg || !out_stall);
    assign at_end = (idx_reg == head_cmd.count - 1'b1);
    assign pop    = load && at_end;

    // Byte index within the current group and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_end ? '0 : idx_reg + 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head_cmd.data[idx_reg[$clog2(CMD_BYTES)-1:0]];
            out_last_reg <= head_cmd.last && at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/percent_encode_decode_stream_top.sv =====
// Top level of the URL percent encoder and decoder.
// The result bytes of an item pass through a queue entry and then the output register.
// Throughput: one result byte per cycle from the output register while out_stall is low, so
// an item that yields one byte is taken every cycle; an encoded escape yields three bytes.
// Reset clears direction to encode, the escape state, the queue and the output valid.
`timescale 1ns / 1ps

module percent_encode_decode_stream_top
    import pcted_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic in_accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic full;
    logic head_valid;
    cmd_t head_cmd;

    // Configuration is taken at once; the user sends it only while idle (unenforced).
    assign cfg_ready = 1'b1;

    // Input side stalls only when the queue is full.
    assign in_stall  = full;
    assign in_accept = in_valid && !full;

    pcted_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_dir   (cfg_data),
        .in_accept (in_accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    pcted_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    pcted_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the URL percent encoder and decoder stream block.
`timescale 1ns / 1ps

module testbench;
    import pcted_pkg::*;

    // One input or result item: a byte and its end-of-string flag.
    typedef struct {
        logic [7:0] b;
        logic       l;
    } byte_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    // Bytes waiting to be sent, and converted bytes still to come out.
    byte_item_t pending_bytes[$];
    byte_item_t expected_bytes[$];
    int         mismatch_count = 0;

    // Predictor state: direction register and the decode escape tracker.
    logic       decode_mode = 1'b0;
    phase_t     esc_phase = PH_IDLE;
    logic [7:0] held_char = 8'h00;

    // Sender and receiver pacing state.
    logic       in_took = 1'b0;
    byte_item_t send_item;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_mode = 0;
    int         seg_left = 0;
    int         hold_left = 0;
    logic       stall_next;

    // The phase directions written after the directed part.
    logic       phase_dirs[8] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    percent_encode_decode_stream_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Value of a hex digit in either case, or -1 for any other byte.
    function automatic int hex_digit_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c - "0");
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c - "A") + 10;
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c - "a") + 10;
        end
        return -1;
    endfunction

    // Letters, digits and the four marks that encoding leaves alone.
    function automatic bit passes_plain(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               c == DASH_CHAR || c == UNDER_CHAR || c == DOT_CHAR || c == TILDE_CHAR;
    endfunction

    // Hex character for a nibble, in upper or lower case.
    function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return 8'("0") + 8'(n);
        end
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    function automatic void expect_byte(input logic [7:0] b);
        byte_item_t r;
        r.b = b;
        r.l = 1'b0;
        expected_bytes.push_back(r);
    endfunction

    // A byte seen with no escape open: it either opens one or passes through.
    function automatic void take_plain(input logic [7:0] b, input logic last);
        if (b == PCT_CHAR && !last)
        begin
            esc_phase = PH_PCT;
        end
        else
        begin
            expect_byte(b);
            esc_phase = PH_IDLE;
        end
    endfunction

    // Works out the converted bytes for one accepted input item.
    function automatic void codec_predict(input logic [7:0] b, input logic last);
        int before_count;
        int hi;
        int lo;
        before_count = expected_bytes.size();
        if (!decode_mode)
        begin
            if (passes_plain(b))
            begin
                expect_byte(b);
            end
            else
            begin
                expect_byte(PCT_CHAR);
                expect_byte(nibble_char(b[7:4], 1'b0));
                expect_byte(nibble_char(b[3:0], 1'b0));
            end
        end
        else if (esc_phase == PH_PCT)
        begin
            if (hex_digit_val(b) >= 0 && !last)
            begin
                held_char = b;
                esc_phase = PH_DIGIT;
            end
            else
            begin
                expect_byte(PCT_CHAR);
                take_plain(b, last);
            end
        end
        else if (esc_phase == PH_DIGIT)
        begin
            hi = hex_digit_val(held_char);
            lo = hex_digit_val(b);
            if (hi >= 0 && lo >= 0)
            begin
                expect_byte(8'(hi * 16 + lo));
                esc_phase = PH_IDLE;
            end
            else
            begin
                expect_byte(PCT_CHAR);
                expect_byte(held_char);
                take_plain(b, last);
            end
            held_char = 8'h00;
        end
        else
        begin
            take_plain(b, last);
        end
        // The end flag rides on the final byte this item produced.
        if (last && expected_bytes.size() > before_count)
        begin
            expected_bytes[expected_bytes.size() - 1].l = 1'b1;
        end
    endfunction

    // Monitor: checks results, then predicts from accepted items and writes.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            in_took <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte: no item expected, got %02h", out_byte);
                    mismatch_count++;
                end
                else
                begin
                    if (out_byte !== expected_bytes[0].b)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               expected_bytes[0].b, out_byte);
                        mismatch_count++;
                    end
                    if (out_last !== expected_bytes[0].l)
                    begin
                        $error("out_last: expected %0b, got %0b",
                               expected_bytes[0].l, out_last);
                        mismatch_count++;
                    end
                    void'(expected_bytes.pop_front());
                end
            end
            if (in_valid && !in_stall)
            begin
                codec_predict(in_byte, in_last);
            end
            // A direction write also drops any half-read escape.
            if (cfg_valid && cfg_ready)
            begin
                decode_mode = cfg_data;
                esc_phase = PH_IDLE;
                held_char = 8'h00;
            end
        end
    end

    // Driver: sends queued items in bursts with random gaps between them.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                send_item = pending_bytes.pop_front();
                in_byte <= send_item.b;
                in_last <= send_item.l;
                in_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: segments of no stall, coin flips, alternation and long holds.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (seg_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 60);
            end
            else
            begin
                seg_left--;
            end
            case (stall_mode)
                0: stall_next = 1'b0;
                1: stall_next = 1'($urandom_range(0, 1));
                2: stall_next = !out_stall;
                default:
                begin
                    if (hold_left > 0)
                    begin
                        hold_left--;
                        stall_next = 1'b1;
                    end
                    else
                    begin
                        stall_next = 1'b0;
                        if ($urandom_range(0, 3) == 0)
                        begin
                            hold_left = $urandom_range(1, 7);
                        end
                    end
                end
            endcase
            out_stall <= stall_next;
        end
    end

    function automatic void queue_byte(input logic [7:0] b, input logic last);
        byte_item_t r;
        r.b = b;
        r.l = last;
        pending_bytes.push_back(r);
    endfunction

    // Queues a byte with a random end-of-string flag.
    function automatic void queue_random_last(input logic [7:0] b);
        queue_byte(b, $urandom_range(0, 11) == 0);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_digit_val(c) >= 0)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Random raw bytes for encoding, weighted toward the pass-through set.
    function automatic void queue_encode_items(input int count);
        string plain_set;
        plain_set = "AZaz09-_.~Mq5";
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                queue_random_last(plain_set[$urandom_range(0, plain_set.len() - 1)]);
            end
            else
            begin
                queue_random_last(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // Mostly well-formed escapes with random content, plus plain bytes and broken escapes.
    function automatic void queue_decode_items(input int count);
        int start_size;
        int pick;
        logic [7:0] v;
        start_size = pending_bytes.size();
        while (pending_bytes.size() - start_size < count)
        begin
            pick = $urandom_range(0, 99);
            v = 8'($urandom_range(0, 255));
            if (pick < 55)
            begin
                queue_random_last(PCT_CHAR);
                queue_random_last(nibble_char(v[7:4], 1'($urandom_range(0, 1))));
                queue_random_last(nibble_char(v[3:0], 1'($urandom_range(0, 1))));
            end
            else if (pick < 75)
            begin
                queue_random_last(v);
            end
            else if (pick < 85)
            begin
                queue_random_last(PCT_CHAR);
                queue_random_last(random_non_hex());
            end
            else if (pick < 95)
            begin
                queue_random_last(PCT_CHAR);
                queue_random_last(nibble_char(v[3:0], 1'($urandom_range(0, 1))));
                queue_random_last(random_non_hex());
            end
            else
            begin
                queue_random_last(PCT_CHAR);
            end
        end
    endfunction

    // Waits until every item is sent and every result has come, then lets the block settle.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= dir;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Main sequence: reset, directed encode and decode, then random phases.
    initial
    begin
        logic [7:0] enc_directed[10];
        string dec_directed;
        enc_directed = '{8'h00, 8'hFF, "A", "z", "0", DASH_CHAR, UNDER_CHAR, DOT_CHAR,
                         TILDE_CHAR, PCT_CHAR};
        dec_directed = "%41%6a%4G%%7e%4";

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Encode with the direction left at its reset value.
        for (int i = 0; i < 10; i++)
        begin
            queue_byte(enc_directed[i], i == 9);
        end
        wait_drained();

        // Decode: good escapes in both cases, bad digits, escape cut off by the end flag.
        write_direction(1'b1);
        for (int i = 0; i < dec_directed.len(); i++)
        begin
            queue_byte(dec_directed[i], i == dec_directed.len() - 1);
        end
        queue_byte(PCT_CHAR, 1'b1);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            write_direction(phase_dirs[p]);
            if (phase_dirs[p])
            begin
                queue_decode_items(26);
            end
            else
            begin
                queue_encode_items(26);
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $error("out_byte: %0d expected items never arrived", expected_bytes.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Timeout.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pcted_pkg.sv
hw/rtl/pcted_front.sv
hw/rtl/pcted_queue.sv
hw/rtl/pcted_back.sv
hw/rtl/percent_encode_decode_stream_top.sv
tb/testbench.sv
